// ===== rtl/crc16_byte_stuffing_framer_top_defines.svh =====
// ---------------------------------------------------------------------------
// crc16 framer assertion macros
// shared property shorthands for the framer checks
// ---------------------------------------------------------------------------
`ifndef CRC16_BYTE_STUFFING_FRAMER_TOP_DEFINES_SVH
`define CRC16_BYTE_STUFFING_FRAMER_TOP_DEFINES_SVH

// same-cycle implication
`define FRM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FRM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cbsf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbsf_pkg
// shared types, constants and the crc-16 table for the framer
// ---------------------------------------------------------------------------
package cbsf_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // one classified message byte
    typedef struct packed {
        logic        open;
        logic        last;
        logic [7:0]  data;
        logic [15:0] crc;
    } t_cmd;

    // wire-byte step of the back sequencer
    typedef enum logic [2:0] {
        PH_OPEN,
        PH_DATA,
        PH_DATA2,
        PH_CRCL,
        PH_CRCL2,
        PH_CRCH,
        PH_CRCH2,
        PH_CLOSE
    } t_phase;

    // table entry: idx<<8 divided msb-first by the polynomial
    function automatic logic [15:0] crc_table(input logic [7:0] idx);
        logic [15:0] c;
        c = {idx, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // byte needs an escape
    function automatic logic needs_esc(input logic [7:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

endpackage

// ===== rtl/cbsf_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbsf_front
// accepts message bytes, tracks frame state, folds crc, issues commands
// ---------------------------------------------------------------------------
module cbsf_front
    import cbsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data,
    input  logic       i_last,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd,
    output logic       o_inside
);

    logic        r_inside;
    logic [15:0] r_crc;
    logic        w_open;
    logic [15:0] w_crc_in;
    logic [15:0] w_crc_new;

    // crc update, cleared at frame open
    always_comb begin
        w_open    = !r_inside;
        w_crc_in  = w_open ? 16'h0000 : r_crc;
        w_crc_new = crc_table(w_crc_in[15:8]) ^ {w_crc_in[7:0], 8'h00} ^ {8'h00, i_data};
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;

    // command toward the back
    always_comb begin
        o_cmd.open = w_open;
        o_cmd.last = i_last;
        o_cmd.data = i_data;
        o_cmd.crc  = w_crc_new;
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_crc    <= 16'h0000;
        end else if (o_push) begin
            r_inside <= !i_last;
            r_crc    <= w_crc_new;
        end
    end

    assign o_inside = r_inside;

endmodule

// ===== rtl/cbsf_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbsf_queue
// small command fifo decoupling front and back
// ---------------------------------------------------------------------------
module cbsf_queue
    import cbsf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QCW-1:0] r_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QAW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

endmodule

// ===== rtl/cbsf_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbsf_back
// sequences flags, stuffed data and stuffed crc into wire bytes
// ---------------------------------------------------------------------------
module cbsf_back
    import cbsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_cmd       i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_end,
    output logic       o_last
);

    t_phase     r_phase;
    t_phase     n_phase;
    t_phase     w_eff;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic       r_last;
    logic       w_load;
    logic [7:0] w_byte;
    logic       w_end;
    logic       w_done;

    // load the output register when a command waits and the register is free or being drained
    assign w_load = i_head_valid && (!r_valid || i_ready);
    assign o_pop  = w_load && w_done;

    // wire byte selection and next step
    always_comb begin
        w_eff   = (r_phase == PH_OPEN && !i_head.open) ? PH_DATA : r_phase;
        w_byte  = i_head.data;
        w_end   = 1'b0;
        w_done  = 1'b0;
        n_phase = w_eff;
        case (w_eff)
            PH_OPEN: begin
                w_byte  = FLAG_BYTE;
                n_phase = PH_DATA;
            end
            PH_DATA: begin
                if (needs_esc(i_head.data)) begin
                    w_byte  = ESC_BYTE;
                    n_phase = PH_DATA2;
                end else begin
                    w_byte  = i_head.data;
                    n_phase = PH_CRCL;
                    w_done  = !i_head.last;
                end
            end
            PH_DATA2: begin
                w_byte  = i_head.data ^ ESC_XOR;
                n_phase = PH_CRCL;
                w_done  = !i_head.last;
            end
            PH_CRCL: begin
                if (needs_esc(i_head.crc[7:0])) begin
                    w_byte  = ESC_BYTE;
                    n_phase = PH_CRCL2;
                end else begin
                    w_byte  = i_head.crc[7:0];
                    n_phase = PH_CRCH;
                end
            end
            PH_CRCL2: begin
                w_byte  = i_head.crc[7:0] ^ ESC_XOR;
                n_phase = PH_CRCH;
            end
            PH_CRCH: begin
                if (needs_esc(i_head.crc[15:8])) begin
                    w_byte  = ESC_BYTE;
                    n_phase = PH_CRCH2;
                end else begin
                    w_byte  = i_head.crc[15:8];
                    n_phase = PH_CLOSE;
                end
            end
            PH_CRCH2: begin
                w_byte  = i_head.crc[15:8] ^ ESC_XOR;
                n_phase = PH_CLOSE;
            end
            PH_CLOSE: begin
                w_byte = FLAG_BYTE;
                w_end  = 1'b1;
                w_done = 1'b1;
            end
            default: begin
                w_byte  = FLAG_BYTE;
                n_phase = PH_OPEN;
            end
        endcase
        if (w_done) begin
            n_phase = PH_OPEN;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPEN;
        end else if (w_load) begin
            r_phase <= n_phase;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_end  <= w_end;
            r_last <= w_done;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_end   = r_end;
    assign o_last  = r_last;

endmodule

// ===== rtl/crc16_byte_stuffing_framer_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc16_byte_stuffing_framer_top
// message framer: opening flag, crc-16 (0x1021), byte stuffing, closing flag
// ---------------------------------------------------------------------------
// channel   dir  tdata                tuser         tlast
// s_axis    in   [7:0] in_byte        -             last_byte
// m_axis    out  [7:0] out_byte       [0] frame_end last_of_run
//
// one wire byte leaves per cycle while the sink is ready and a command waits;
// an input byte becomes one to eight wire bytes (two for a stuffed byte, more
// for the opening flag and crc trailer); the back sequencer sets the rate;
// the front takes a byte per cycle while the four-entry command queue has room
// synchronous active-low reset empties the queue and closes any open frame
// a stalled output holds its byte; the queue keeps the front running meanwhile
// ---------------------------------------------------------------------------
`include "crc16_byte_stuffing_framer_top_defines.svh"

module crc16_byte_stuffing_framer_top
    import cbsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tuser,   // [0] frame_end
    output logic       o_m_axis_tlast
);

    logic w_push;
    t_cmd w_cmd;
    logic w_q_full;
    logic w_q_valid;
    t_cmd w_head;
    logic w_pop;
    logic w_inside;
    logic w_s_xfer;
    logic w_s_more;
    logic w_close_seen;
    logic w_close_ok;
    logic w_esc_seen;
    logic w_run_open;
    logic w_run_end;

    // front: accept and fold crc
    cbsf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_data   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .i_q_full (w_q_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (w_push),
        .o_cmd    (w_cmd),
        .o_inside (w_inside)
    );

    // command queue
    cbsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    // back: wire byte sequencer
    cbsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_q_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_byte       (o_m_axis_tdata),
        .o_end        (o_m_axis_tuser),
        .o_last       (o_m_axis_tlast)
    );

    // terms for the checks below
    assign w_s_xfer     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_s_more     = !i_s_axis_tlast;
    assign w_close_seen = o_m_axis_tvalid && o_m_axis_tuser;
    assign w_close_ok   = (o_m_axis_tdata == FLAG_BYTE) && o_m_axis_tlast;
    assign w_esc_seen   = o_m_axis_tvalid && (o_m_axis_tdata == ESC_BYTE);
    assign w_run_open   = !o_m_axis_tlast && !o_m_axis_tuser;
    assign w_run_end    = o_m_axis_tvalid && o_m_axis_tlast;

    // closing flag is a raw flag and ends the run
    `FRM_ASSERT_IMP(a_close_flag, i_clk, i_rst_n, w_close_seen, w_close_ok, "bad closing flag")

    // an escape byte always has a follower in the same run
    `FRM_ASSERT_IMP(a_esc_not_last, i_clk, i_rst_n, w_esc_seen, w_run_open, "escape ends a run")

    // frame state follows the last-byte marker of each accepted transaction
    `FRM_ASSERT_NXT(a_frame_state, i_clk, i_rst_n, w_s_xfer, w_inside == $past(w_s_more), "frame state")

    // a popped command is always the end of a run on the output
    `FRM_ASSERT_NXT(a_pop_marks_last, i_clk, i_rst_n, w_pop, w_run_end, "pop without run end")

endmodule
